// ===== src/dcm_pkg.sv =====
// Package for the disparity colour map block: pipeline sizing, register map,
// colour scale tables and the stage handoff type.
// Depends on nothing; used by every module of the block.
package dcm_pkg;

	// Default disparity width (unsigned Q8.8 at 16 bits)
	localparam int DISP_BITS_DEF = 16;

	// Divider: 16 quotient bits, a fixed number of restoring steps per stage
	localparam int DIV_BITS   = 16;
	localparam int DIV_STEPS  = 2;
	localparam int DIV_STAGES = DIV_BITS / DIV_STEPS;

	// Register stages from accept to result: prep, divider, three blend stages
	localparam int PIPE_DEPTH = DIV_STAGES + 4;

	// Configuration port
	localparam int          ADDR_W        = 3;
	localparam logic        REG_MAX_DISP  = 1'b0;
	localparam logic [15:0] MAX_DISP_RST  = 16'd24576;

	// Pixel modes
	localparam logic MODE_COLOR = 1'b0;
	localparam logic MODE_GREY  = 1'b1;

	// Segment breakpoints (Q1.16) and slopes (Q4.12) of the colour scale
	localparam logic [16:0] BRK [8] = '{
		17'd0, 17'd7471, 17'd19595, 17'd27066,
		17'd38470, 17'd45941, 17'd58065, 17'd65536
	};
	localparam logic [15:0] SLOPE [7] = '{
		16'd35930, 16'd22141, 16'd35930, 16'd23540,
		16'd35930, 16'd22141, 16'd35930
	};

	// Control group that travels with each item through the pipeline
	typedef struct packed {
		logic valid;
		logic mode;
		logic sat;
	} dcm_ctl_t;

	// Endpoint colour of scale entry idx; bit k is channel k (0/1)
	function automatic logic [2:0] cmap_bits(input logic [2:0] idx);
		cmap_bits = {idx[0], idx[2], idx[1]};
	endfunction

endpackage

// ===== src/dcm_prep.sv =====
// First stage: forms the divider operands for colour and grey mode and the
// saturation flag. Depends on dcm_pkg.
module dcm_prep
	import dcm_pkg::*;
#(
	parameter int DISP_BITS = DISP_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [DISP_BITS-1:0] disparity,
	input  logic                 mode,
	input  logic [15:0]          max_eff,
	output dcm_ctl_t             ctl_s1,
	output logic [15:0]          rem_s1,
	output logic [15:0]          low_s1
);

	localparam int NUM_W = ((DISP_BITS + 8 > 16) ? DISP_BITS + 8 : 16) + 1;
	localparam int CMP_W = (DISP_BITS + 1 > 17) ? DISP_BITS + 1 : 17;

	logic [NUM_W-1:0] gnum;
	logic [CMP_W-1:0] hi;
	logic             sat;
	logic [15:0]      rem0;
	logic [15:0]      low0;

	// Grey numerator d*255 + floor(max/2); split into high part and 8 low bits
	always_comb begin
		gnum = (NUM_W'(disparity) << 8) - NUM_W'(disparity) + NUM_W'(max_eff >> 1);
		if (mode == MODE_GREY) begin
			hi   = CMP_W'(gnum[NUM_W-1:8]);
			low0 = {gnum[7:0], 8'd0};
		end else begin
			hi   = CMP_W'(disparity);
			low0 = 16'd0;
		end
		sat  = (hi >= CMP_W'(max_eff));
		rem0 = sat ? 16'd0 : hi[15:0];
	end

	// Hold control with reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid <= accept;
			if (accept) begin
				ctl_s1.mode <= mode;
				ctl_s1.sat  <= sat;
			end
		end
	end

	// Capture operands on a transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			rem_s1 <= rem0;
			low_s1 <= low0;
		end
	end

endmodule

// ===== src/dcm_div.sv =====
// Pipelined restoring divider, DIV_STEPS quotient bits per stage.
// Remainder starts below the divisor; low bits are shifted in. Depends on dcm_pkg.
module dcm_div
	import dcm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [15:0]       max_eff,
	input  dcm_ctl_t          ctl_in,
	input  logic [15:0]       rem_in,
	input  logic [15:0]       low_in,
	output dcm_ctl_t          ctl_out,
	output logic [DIV_BITS-1:0] quot_out
);

	dcm_ctl_t            ctl_s  [DIV_STAGES];
	logic [15:0]         rem_s  [DIV_STAGES];
	logic [15:0]         low_s  [DIV_STAGES];
	logic [DIV_BITS-1:0] quot_s [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		dcm_ctl_t            c_in;
		logic [15:0]         r_in;
		logic [15:0]         l_in;
		logic [DIV_BITS-1:0] q_in;
		logic [15:0]         r_nx;
		logic [15:0]         l_nx;
		logic [DIV_BITS-1:0] q_nx;

		if (k == 0) begin : g_first
			assign c_in = ctl_in;
			assign r_in = rem_in;
			assign l_in = low_in;
			assign q_in = '0;
		end else begin : g_next
			assign c_in = ctl_s[k-1];
			assign r_in = rem_s[k-1];
			assign l_in = low_s[k-1];
			assign q_in = quot_s[k-1];
		end

		// Shift in one bit, subtract the divisor where it fits
		always_comb begin
			logic [16:0] r2;
			r_nx = r_in;
			l_nx = l_in;
			q_nx = q_in;
			for (int j = 0; j < DIV_STEPS; j++) begin
				r2   = {r_nx, l_nx[15]};
				l_nx = {l_nx[14:0], 1'b0};
				if (r2 >= {1'b0, max_eff}) begin
					r2   = r2 - {1'b0, max_eff};
					q_nx = {q_nx[DIV_BITS-2:0], 1'b1};
				end else begin
					q_nx = {q_nx[DIV_BITS-2:0], 1'b0};
				end
				r_nx = r2[15:0];
			end
		end

		// Advance control
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k] <= '0;
			end else begin
				ctl_s[k] <= c_in;
			end
		end

		// Advance payload
		always_ff @(posedge clk) begin
			rem_s[k]  <= r_nx;
			low_s[k]  <= l_nx;
			quot_s[k] <= q_nx;
		end
	end

	assign ctl_out  = ctl_s[DIV_STAGES-1];
	assign quot_out = quot_s[DIV_STAGES-1];

endmodule

// ===== src/dcm_blend.sv =====
// Colour scale stages: segment search, slope multiply, endpoint blend, and
// grey saturation; drives the result registers. Depends on dcm_pkg.
module dcm_blend
	import dcm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  dcm_ctl_t            ctl_in,
	input  logic [DIV_BITS-1:0] quot_in,
	output logic                done,
	output logic [7:0]          chan0,
	output logic [7:0]          chan1,
	output logic [7:0]          chan2
);

	logic        valid_s10, valid_s11, valid_s12;
	logic        mode_s10, mode_s11;
	logic [7:0]  grey_s10, grey_s11;
	logic [2:0]  seg_s10, seg_s11;
	logic [16:0] diff_s10;
	logic [32:0] prod_s11;
	logic [7:0]  chan_s12 [3];

	logic [16:0] cval;
	logic [2:0]  seg;
	logic [7:0]  grey;

	// Normalized value, segment search over the breakpoints, grey clamp
	always_comb begin
		cval = ctl_in.sat ? 17'd65536 : {1'b0, quot_in};
		seg  = 3'd0;
		for (int i = 1; i < 7; i++) begin
			if (cval > BRK[i]) begin
				seg = 3'(i);
			end
		end
		grey = ctl_in.sat ? 8'd255 : quot_in[DIV_BITS-1:DIV_BITS-8];
	end

	// Valid bits with reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s10 <= 1'b0;
			valid_s11 <= 1'b0;
			valid_s12 <= 1'b0;
		end else begin
			valid_s10 <= ctl_in.valid;
			valid_s11 <= valid_s10;
			valid_s12 <= valid_s11;
		end
	end

	// Offset into the segment, then slope product
	always_ff @(posedge clk) begin
		mode_s10 <= ctl_in.mode;
		grey_s10 <= grey;
		seg_s10  <= seg;
		diff_s10 <= cval - BRK[seg];
		mode_s11 <= mode_s10;
		grey_s11 <= grey_s10;
		seg_s11  <= seg_s10;
		prod_s11 <= diff_s10 * SLOPE[seg_s10];
	end

	logic [16:0] tq;
	logic [16:0] wq;
	logic [2:0]  lo_c;
	logic [2:0]  hi_c;
	logic [7:0]  chan_nx [3];

	// Clamp blend factor, weight the endpoints, scale to 8 bits
	always_comb begin
		logic [16:0] v;
		logic [24:0] v255;
		tq   = (prod_s11[32:12] > 21'd65536) ? 17'd65536 : prod_s11[28:12];
		wq   = 17'd65536 - tq;
		lo_c = cmap_bits(seg_s11);
		hi_c = cmap_bits(seg_s11 + 3'd1);
		for (int k = 0; k < 3; k++) begin
			case ({lo_c[k], hi_c[k]})
				2'b11:   v = 17'd65536;
				2'b10:   v = wq;
				2'b01:   v = tq;
				default: v = 17'd0;
			endcase
			v255 = {v, 8'd0} - 25'(v);
			chan_nx[k] = (mode_s11 == MODE_GREY) ? grey_s11 : v255[23:16];
		end
	end

	// Result registers
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			chan_s12[k] <= chan_nx[k];
		end
	end

	assign done  = valid_s12;
	assign chan0 = chan_s12[0];
	assign chan1 = chan_s12[1];
	assign chan2 = chan_s12[2];

endmodule

// ===== src/disparity_colormap_top.sv =====
// Disparity colour map: one disparity pixel in, one RGB pixel out.
// Pipeline: done follows the accepting edge through one prep stage, eight
// divider stages of two quotient bits each, and three blend stages.
// Throughput: one pixel per clock; busy stays low and done is a one-cycle strobe.
// Reset: arst_n clears all valid bits and loads max_disparity with 96.0 (24576).
module disparity_colormap_top
	import dcm_pkg::*;
#(
	parameter int DISP_BITS = DISP_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [DISP_BITS-1:0] disparity,
	input  logic                 mode,
	output logic                 done,
	output logic [7:0]           chan0,
	output logic [7:0]           chan1,
	output logic [7:0]           chan2,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_W-1:0]    paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	logic [15:0]         full_scale_q;
	logic [15:0]         max_eff;
	logic                accept;
	dcm_ctl_t            ctl_s1;
	logic [15:0]         rem_s1;
	logic [15:0]         low_s1;
	dcm_ctl_t            ctl_div;
	logic [DIV_BITS-1:0] quot_div;

	// Register write on the access phase of a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_scale_q <= MAX_DISP_RST;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_DISP) begin
			full_scale_q <= pwdata[15:0];
		end
	end

	// Register read
	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_MAX_DISP) begin
			prdata = {16'd0, full_scale_q};
		end
	end

	assign pready  = 1'b1;
	assign busy    = 1'b0;
	assign accept  = start && !busy;
	assign max_eff = (full_scale_q == 16'd0) ? 16'd1 : full_scale_q;

	dcm_prep #(
		.DISP_BITS(DISP_BITS)
	) u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.disparity (disparity),
		.mode      (mode),
		.max_eff   (max_eff),
		.ctl_s1    (ctl_s1),
		.rem_s1    (rem_s1),
		.low_s1    (low_s1)
	);

	dcm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.max_eff  (max_eff),
		.ctl_in   (ctl_s1),
		.rem_in   (rem_s1),
		.low_in   (low_s1),
		.ctl_out  (ctl_div),
		.quot_out (quot_div)
	);

	dcm_blend u_blend (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_in  (ctl_div),
		.quot_in (quot_div),
		.done    (done),
		.chan0   (chan0),
		.chan1   (chan1),
		.chan2   (chan2)
	);

endmodule

// ===== src/dcm_checker.sv =====
// Port-level checks of the disparity colour map, bound to the top level.
// Depends on dcm_pkg and disparity_colormap_top.
module dcm_checker
	import dcm_pkg::*;
#(
	parameter int DISP_BITS = DISP_BITS_DEF
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input logic [DISP_BITS-1:0] disparity,
	input logic                 mode,
	input logic                 done,
	input logic [7:0]           chan0,
	input logic [7:0]           chan1,
	input logic [7:0]           chan2
);

	// Every result comes from an earlier input transfer
	a_done_has_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, PIPE_DEPTH))
		else $error("result strobe without matching input transfer");

	// Every transfer yields a result
	a_src_has_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##PIPE_DEPTH done)
		else $error("input transfer produced no result");

	// Grey pixels carry the same value on all channels
	a_grey_equal: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(mode, PIPE_DEPTH) == MODE_GREY) |-> (chan0 == chan1 && chan1 == chan2))
		else $error("grey result with unequal channels");

	// Zero disparity in colour mode maps to black
	a_zero_black: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(mode, PIPE_DEPTH) == MODE_COLOR && $past(disparity, PIPE_DEPTH) == '0)
		|-> (chan0 == 8'd0 && chan1 == 8'd0 && chan2 == 8'd0))
		else $error("zero disparity not black");

endmodule

bind disparity_colormap_top dcm_checker #(
	.DISP_BITS(DISP_BITS)
) u_dcm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.disparity (disparity),
	.mode      (mode),
	.done      (done),
	.chan0     (chan0),
	.chan1     (chan1),
	.chan2     (chan2)
);
